// File: rtl/sbw_pkg.sv
// ----------------------------------------------------------------------------
// sbw_pkg
// Types and constants shared by the surface blend weight pipeline.
// ----------------------------------------------------------------------------
package sbw_pkg;

  localparam int IDX_W      = 10;
  localparam int REG_W      = 11;
  localparam int W_W        = 16;
  localparam int FRAC_BITS  = 15;
  localparam int MAX_DIM    = 1024;
  localparam int DEN_W      = REG_W + 1;
  localparam int DIV_STAGES = 5;
  localparam int STAGE_BITS = FRAC_BITS / DIV_STAGES;
  localparam int CFG_IDX_W  = 3;

  localparam logic [W_W-1:0]   Q_ONE   = W_W'(1) << FRAC_BITS;
  localparam logic [W_W-1:0]   Q_HALF  = W_W'(1) << (FRAC_BITS - 1);
  localparam logic [REG_W-1:0] DIM_MAX = REG_W'(MAX_DIM);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_COLS          = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS          = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_ROW_BAND  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_COL_BAND = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_ROW_BAND = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_COL_BAND  = 3'd5;

  typedef struct packed {
    logic [REG_W-1:0] cols;
    logic [REG_W-1:0] rows;
    logic [REG_W-1:0] low_row_band;
    logic [REG_W-1:0] high_col_band;
    logic [REG_W-1:0] high_row_band;
    logic [REG_W-1:0] low_col_band;
  } cfg_t;

  // what travels beside the divider
  typedef struct packed {
    logic           err;
    logic           intr;
    logic [W_W-1:0] fixw;
  } side_t;

  typedef struct packed {
    logic [DEN_W-1:0]     rem;
    logic [DEN_W-1:0]     den;
    logic [FRAC_BITS-1:0] quo;
  } div_t;

endpackage

// File: rtl/surface_blend_weight.sv
// ----------------------------------------------------------------------------
// surface_blend_weight
// Streams one element of the surface blending weight matrix per request.
// ----------------------------------------------------------------------------
//  channel  direction  content
//  in_      slave      tdata = row_index[9:0], col_index[19:10]
//  out_     master     tdata = weight[15:0] (Q1.15); tuser = index_error
//  cfg_     write      cfg_index selects register, cfg_wdata 11 bits
//
//  one request per cycle sustained while out_tready does not stall; stages are decode,
//  five divider stages of three quotient bits each, and the output register
//  the fifteen-step restoring divider sets the depth
//  rst_n is synchronous, clears the pipeline and reloads register defaults
//  each stage holds under stall and loads when it is empty or its successor
//  moves, so empty stages fill while the output waits
// ----------------------------------------------------------------------------
module surface_blend_weight import sbw_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [23:0]          in_tdata,   // row_index[9:0], col_index[19:10]
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [15:0]          out_tdata,  // weight[15:0]
  output logic [0:0]           out_tuser,  // index_error[0]
  input  logic                 cfg_wen,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [REG_W-1:0]     cfg_wdata
);

  logic [REG_W-1:0] cols_r, rows_r, lrb_r, hcb_r, hrb_r, lcb_r;
  cfg_t             cfg;

  logic             vld_s  [DIV_STAGES+1];
  side_t            side_s [DIV_STAGES+1];
  div_t             dv_s   [DIV_STAGES+1];
  logic             ld_s   [DIV_STAGES+2];

  logic             out_vld_r;
  logic [W_W-1:0]   out_w_r, out_w_nxt;
  logic             out_err_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_r <= REG_W'(4);
      rows_r <= REG_W'(4);
      lrb_r  <= REG_W'(1);
      hcb_r  <= REG_W'(1);
      hrb_r  <= REG_W'(1);
      lcb_r  <= REG_W'(1);
    end else if (cfg_wen) begin
      case (cfg_index)
        REG_COLS:          cols_r <= cfg_wdata;
        REG_ROWS:          rows_r <= cfg_wdata;
        REG_LOW_ROW_BAND:  lrb_r  <= cfg_wdata;
        REG_HIGH_COL_BAND: hcb_r  <= cfg_wdata;
        REG_HIGH_ROW_BAND: hrb_r  <= cfg_wdata;
        REG_LOW_COL_BAND:  lcb_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // sizes above the maximum act as the maximum
  always_comb begin
    cfg.cols          = (cols_r > DIM_MAX) ? DIM_MAX : cols_r;
    cfg.rows          = (rows_r > DIM_MAX) ? DIM_MAX : rows_r;
    cfg.low_row_band  = lrb_r;
    cfg.high_col_band = hcb_r;
    cfg.high_row_band = hrb_r;
    cfg.low_col_band  = lcb_r;
  end

  assign ld_s[DIV_STAGES+1] = !out_vld_r || out_tready;

  for (genvar k = 0; k <= DIV_STAGES; k++) begin : g_ld
    assign ld_s[k] = !vld_s[k] || ld_s[k+1];
  end

  assign in_tready = ld_s[0];

  sbw_decode u_dec (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg),
    .in_vld (in_tvalid),
    .ld     (ld_s[0]),
    .row    (in_tdata[9:0]),
    .col    (in_tdata[19:10]),
    .vld    (vld_s[0]),
    .side   (side_s[0]),
    .dv     (dv_s[0])
  );

  for (genvar k = 1; k <= DIV_STAGES; k++) begin : g_div
    sbw_div_stage u_div (
      .clk     (clk),
      .rst_n   (rst_n),
      .in_vld  (vld_s[k-1]),
      .ld      (ld_s[k]),
      .in_side (side_s[k-1]),
      .in_dv   (dv_s[k-1]),
      .vld     (vld_s[k]),
      .side    (side_s[k]),
      .dv      (dv_s[k])
    );
  end

  always_comb begin
    if (side_s[DIV_STAGES].err) begin
      out_w_nxt = '0;
    end else if (side_s[DIV_STAGES].intr) begin
      out_w_nxt = W_W'(dv_s[DIV_STAGES].quo);
    end else begin
      out_w_nxt = side_s[DIV_STAGES].fixw;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (ld_s[DIV_STAGES+1]) begin
      out_vld_r <= vld_s[DIV_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (ld_s[DIV_STAGES+1]) begin
      out_w_r   <= out_w_nxt;
      out_err_r <= side_s[DIV_STAGES].err;
    end
  end

  assign out_tvalid   = out_vld_r;
  assign out_tdata    = out_w_r;
  assign out_tuser[0] = out_err_r;

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[0]) |-> (out_tdata == '0))
    else $error("out of range request returned a nonzero weight");

  a_weight_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata <= Q_ONE))
    else $error("weight above one");

  a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && (REG_W'(in_tdata[9:0]) >= cfg.rows))
    |=> side_s[0].err)
    else $error("row beyond size not flagged at decode");

endmodule

// File: rtl/sbw_decode.sv
// ----------------------------------------------------------------------------
// sbw_decode
// First pipeline stage: range check, region selection, fixed weights and
// the numerator and denominator of the interior quotient.
// ----------------------------------------------------------------------------
module sbw_decode import sbw_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  cfg_t             cfg,
  input  logic             in_vld,
  input  logic             ld,
  input  logic [IDX_W-1:0] row,
  input  logic [IDX_W-1:0] col,
  output logic             vld,
  output side_t            side,
  output div_t             dv
);

  logic              vld_r;
  side_t             side_r, side_nxt;
  div_t              dv_r, dv_nxt;

  logic [REG_W-1:0]  r11, c11;
  logic [DEN_W-1:0]  r12, c12;
  logic              r_ge_a, rd_lt_rows, c_ge_e, cb_lt_cols;
  logic              top, left, inner, half_band;
  logic              r_zero, r_last, r_hi, r_lo, c_zero, c_last;
  logic [W_W-1:0]    band_w;
  logic [REG_W-1:0]  num, oth;

  always_comb begin
    r11 = REG_W'(row);
    c11 = REG_W'(col);
    r12 = DEN_W'(row);
    c12 = DEN_W'(col);

    side_nxt.err = (r11 >= cfg.rows) || (c11 >= cfg.cols);

    r_ge_a     = r11 >= cfg.low_row_band;
    rd_lt_rows = (r12 + DEN_W'(cfg.high_row_band)) < DEN_W'(cfg.rows);
    c_ge_e     = c11 >= cfg.low_col_band;
    cb_lt_cols = (c12 + DEN_W'(cfg.high_col_band)) < DEN_W'(cfg.cols);
    side_nxt.intr = r_ge_a && rd_lt_rows && c_ge_e && cb_lt_cols;

    // midpoint tests: 2(i+1) <= n+1 is 2i+1 <= n
    top  = (DEN_W'({r11, 1'b0}) + DEN_W'(1)) <= DEN_W'(cfg.rows);
    left = (DEN_W'({c11, 1'b0}) + DEN_W'(1)) <= DEN_W'(cfg.cols);

    inner     = (col != '0) && ((c12 + DEN_W'(2)) <= DEN_W'(cfg.cols));
    half_band = !c_ge_e || !cb_lt_cols;
    band_w    = half_band ? Q_HALF : Q_ONE;

    r_zero = row == '0;
    r_last = (r12 + DEN_W'(1)) == DEN_W'(cfg.rows);
    r_hi   = !rd_lt_rows && ((r12 + DEN_W'(1)) < DEN_W'(cfg.rows));
    r_lo   = !r_zero && (r11 < cfg.low_row_band);
    c_zero = col == '0;
    c_last = (c12 + DEN_W'(1)) == DEN_W'(cfg.cols);

    if (inner) begin
      if (r_hi) begin
        side_nxt.fixw = band_w;
      end else if (r_last) begin
        side_nxt.fixw = Q_ONE;
      end else if (r_lo) begin
        side_nxt.fixw = band_w;
      end else if (r_zero) begin
        side_nxt.fixw = Q_ONE;
      end else begin
        side_nxt.fixw = '0;
      end
    end else if ((r_zero || r_last) && (c_zero || c_last)) begin
      side_nxt.fixw = Q_HALF;
    end else begin
      side_nxt.fixw = '0;
    end

    // den = num + (r+1 on top, R-r below)
    num = left ? (c11 + REG_W'(1)) : (cfg.cols - c11);
    oth = top  ? (r11 + REG_W'(1)) : (cfg.rows - r11);
    dv_nxt.rem = DEN_W'(num);
    dv_nxt.den = DEN_W'(num) + DEN_W'(oth);
    dv_nxt.quo = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (ld) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      side_r <= side_nxt;
      dv_r   <= dv_nxt;
    end
  end

  assign vld  = vld_r;
  assign side = side_r;
  assign dv   = dv_r;

endmodule

// File: rtl/sbw_div_stage.sv
// ----------------------------------------------------------------------------
// sbw_div_stage
// One stage of the restoring fraction divider: three quotient bits per stage.
// ----------------------------------------------------------------------------
module sbw_div_stage import sbw_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_vld,
  input  logic  ld,
  input  side_t in_side,
  input  div_t  in_dv,
  output logic  vld,
  output side_t side,
  output div_t  dv
);

  logic             vld_r;
  side_t            side_r;
  div_t             dv_r, dv_nxt;
  logic [DEN_W:0]   sh;

  // remainder stays below den, so the doubled value fits one extra bit
  always_comb begin
    dv_nxt = in_dv;
    sh     = '0;
    for (int i = 0; i < STAGE_BITS; i++) begin
      sh = {dv_nxt.rem, 1'b0};
      if (sh >= {1'b0, dv_nxt.den}) begin
        dv_nxt.rem = DEN_W'(sh - {1'b0, dv_nxt.den});
        dv_nxt.quo = {dv_nxt.quo[FRAC_BITS-2:0], 1'b1};
      end else begin
        dv_nxt.rem = sh[DEN_W-1:0];
        dv_nxt.quo = {dv_nxt.quo[FRAC_BITS-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (ld) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      side_r <= in_side;
      dv_r   <= dv_nxt;
    end
  end

  assign vld  = vld_r;
  assign side = side_r;
  assign dv   = dv_r;

endmodule
